[hdl/bba_pkg.sv]
// Package for the bitmap block allocator: sizes, codes, payload words and the
// command and status structs that pass between controller and datapath.
// Depends on nothing; every other file imports it.
package bba_pkg;

   localparam int MEM_BLOCKS    = 1024;
   localparam int BLOCK_BYTES   = 16;
   localparam int BLOCK_SHIFT   = $clog2(BLOCK_BYTES);
   localparam int TABLE_ENTRIES = 64;

   localparam int BLK_W  = $clog2(MEM_BLOCKS);
   localparam int LEN_W  = BLK_W + 1;
   localparam int SIZE_W = 16;
   localparam int NBLK_W = SIZE_W - BLOCK_SHIFT + 1;
   localparam int TBL_W  = $clog2(TABLE_ENTRIES);
   localparam int SCAN_W = TBL_W + 1;
   localparam int COL_W  = 5;
   localparam int ROW_W  = BLK_W - COL_W;
   localparam int ROWS   = MEM_BLOCKS / (2 ** COL_W);

   typedef enum logic [1:0] {
      FN_ALLOC   = 2'd0,
      FN_FREE    = 2'd1,
      FN_PROBE   = 2'd2,
      FN_REALLOC = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_ZERO      = 3'd1,
      ST_NOSPACE   = 3'd2,
      ST_TABLEFULL = 3'd3,
      ST_NOTFOUND  = 3'd4,
      ST_NULL      = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_CLEAR,
      S_SEARCH,
      S_RESTORE,
      S_MARK
   } state_type;

   typedef enum logic {
      SRC_OLD,
      SRC_NEW
   } src_type;

   typedef struct packed {
      func_type          func;
      logic [SIZE_W-1:0] size_bytes;
      logic [BLK_W-1:0]  handle_block;
      logic              handle_valid;
   } req_type;

   typedef struct packed {
      status_type       status;
      logic [BLK_W-1:0] start_block;
      logic [LEN_W-1:0] length_blocks;
      logic [LEN_W-1:0] keep_blocks;
   } rsp_type;

   typedef struct packed {
      logic [BLK_W-1:0] start;
      logic [LEN_W-1:0] len;
   } entry_type;

   typedef struct packed {
      logic       load;
      logic       scan_step;
      logic       srch_init;
      logic       srch_step;
      logic       mark_init;
      logic       mark_step;
      logic       mark_old;
      logic       mark_val;
      logic       invalidate;
      logic       commit;
      logic       respond;
      status_type rsp_status;
      src_type    rsp_src;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     size_zero;
      logic     hval;
      logic     hit_old;
      logic     free_found;
      logic     scan_done;
      logic     srch_done;
      logic     srch_hit;
      logic     mark_done;
   } stat_type;

endpackage

[hdl/bba_datapath.sv]
// Datapath of the bitmap block allocator: request word, occupancy bitmap,
// allocation table memory, table scan, first-fit search and run marking.
// Depends on bba_pkg; driven by bba_controller.
module bba_datapath (
   input  logic             clock,
   input  logic             reset,
   input  bba_pkg::req_type req_data,
   input  bba_pkg::cmd_type cmd,
   output bba_pkg::stat_type stat,
   output logic             rsp_strobe,
   output bba_pkg::rsp_type rsp_data
);
   import bba_pkg::*;

   req_type           req_ff;
   logic [NBLK_W-1:0] nblk_ff;
   logic [(2**COL_W)-1:0] bm_ff [ROWS];
   logic [TABLE_ENTRIES-1:0] valid_ff;
   entry_type         tbl_mem [TABLE_ENTRIES];

   logic [SCAN_W-1:0] scan_idx_ff;
   logic              rd_pend_ff;
   logic [TBL_W-1:0]  rd_idx_ff;
   entry_type         rd_data_ff;
   logic              match_found_ff;
   logic [TBL_W-1:0]  match_idx_ff;
   logic [BLK_W-1:0]  match_start_ff;
   logic [LEN_W-1:0]  match_len_ff;
   logic              free_found_ff;
   logic [TBL_W-1:0]  free_idx_ff;

   logic [BLK_W-1:0]  srch_idx_ff;
   logic [LEN_W-1:0]  run_ff;
   logic              srch_done_ff;
   logic              srch_hit_ff;
   logic [BLK_W-1:0]  srch_start_ff;

   logic [LEN_W-1:0]  mark_cnt_ff;
   logic              mark_done_ff;

   logic              strobe_ff;
   rsp_type           rsp_ff;

   logic [NBLK_W-1:0] nblk_in;
   logic              over;
   logic              hit_old;
   logic              srch_bit;
   logic [LEN_W-1:0]  run_in;
   logic              srch_hit_in;
   logic [BLK_W-1:0]  srch_start_in;
   logic [BLK_W-1:0]  mark_base;
   logic [LEN_W-1:0]  mark_len;
   logic [BLK_W-1:0]  mark_addr;
   logic [TBL_W-1:0]  slot;
   logic [LEN_W-1:0]  keep_in;
   logic              rd_match;
   logic [TABLE_ENTRIES-1:0] valid_in;

   assign nblk_in = NBLK_W'(req_data.size_bytes >> BLOCK_SHIFT)
                  + NBLK_W'(|req_data.size_bytes[BLOCK_SHIFT-1:0]);
   assign over    = nblk_ff > NBLK_W'(MEM_BLOCKS);
   assign hit_old = match_found_ff & req_ff.handle_valid;

   assign srch_bit      = bm_ff[srch_idx_ff[BLK_W-1:COL_W]][srch_idx_ff[COL_W-1:0]];
   assign run_in        = srch_bit ? '0 : run_ff + LEN_W'(1);
   assign srch_hit_in   = !srch_bit && (NBLK_W'(run_in) == nblk_ff);
   assign srch_start_in = BLK_W'({1'b0, srch_idx_ff} + LEN_W'(1) - nblk_ff[LEN_W-1:0]);

   assign mark_base = cmd.mark_old ? match_start_ff : srch_start_ff;
   assign mark_len  = cmd.mark_old ? match_len_ff : nblk_ff[LEN_W-1:0];
   assign mark_addr = mark_base + mark_cnt_ff[BLK_W-1:0];

   assign slot = (req_ff.func == FN_REALLOC && hit_old)
               ? ((free_found_ff && free_idx_ff < match_idx_ff) ? free_idx_ff : match_idx_ff)
               : free_idx_ff;
   assign keep_in = (req_ff.func == FN_REALLOC && hit_old)
                  ? ((nblk_ff[LEN_W-1:0] < match_len_ff) ? nblk_ff[LEN_W-1:0] : match_len_ff)
                  : '0;
   assign rd_match = valid_ff[rd_idx_ff] && rd_data_ff.start == req_ff.handle_block;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff  <= req_data;
         nblk_ff <= nblk_in;
      end
   end

   // The table is read one entry a cycle; the compare runs in the cycle after the read, on the registered entry.
   always_ff @(posedge clock) begin
      if (cmd.scan_step && scan_idx_ff < SCAN_W'(TABLE_ENTRIES)) begin
         rd_data_ff <= tbl_mem[scan_idx_ff[TBL_W-1:0]];
      end
      if (cmd.commit) begin
         tbl_mem[slot] <= '{start: srch_start_ff, len: nblk_ff[LEN_W-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff    <= '0;
         rd_pend_ff     <= 1'b0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
      end else if (cmd.load) begin
         scan_idx_ff    <= '0;
         rd_pend_ff     <= 1'b0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
      end else if (cmd.scan_step) begin
         rd_pend_ff <= scan_idx_ff < SCAN_W'(TABLE_ENTRIES);
         rd_idx_ff  <= scan_idx_ff[TBL_W-1:0];
         if (scan_idx_ff < SCAN_W'(TABLE_ENTRIES)) begin
            scan_idx_ff <= scan_idx_ff + SCAN_W'(1);
         end
         if (rd_pend_ff) begin
            if (rd_match && !match_found_ff) begin
               match_found_ff <= 1'b1;
               match_idx_ff   <= rd_idx_ff;
               match_start_ff <= rd_data_ff.start;
               match_len_ff   <= rd_data_ff.len;
            end
            if (!valid_ff[rd_idx_ff] && !free_found_ff) begin
               free_found_ff <= 1'b1;
               free_idx_ff   <= rd_idx_ff;
            end
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.invalidate) begin
         valid_in[match_idx_ff] = 1'b0;
      end
      if (cmd.commit) begin
         if (req_ff.func == FN_REALLOC && hit_old) begin
            valid_in[match_idx_ff] = 1'b0;
         end
         valid_in[slot] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         srch_done_ff <= 1'b0;
         srch_hit_ff  <= 1'b0;
      end else if (cmd.srch_init) begin
         srch_idx_ff  <= '0;
         run_ff       <= '0;
         srch_done_ff <= 1'b0;
         srch_hit_ff  <= 1'b0;
      end else if (cmd.srch_step) begin
         if (over) begin
            srch_done_ff <= 1'b1;
         end else begin
            run_ff      <= run_in;
            srch_idx_ff <= srch_idx_ff + BLK_W'(1);
            if (srch_hit_in) begin
               srch_done_ff  <= 1'b1;
               srch_hit_ff   <= 1'b1;
               srch_start_ff <= srch_start_in;
            end else if (srch_idx_ff == BLK_W'(MEM_BLOCKS - 1)) begin
               srch_done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_done_ff <= 1'b0;
         mark_cnt_ff  <= '0;
      end else if (cmd.mark_init) begin
         mark_done_ff <= 1'b0;
         mark_cnt_ff  <= '0;
      end else if (cmd.mark_step) begin
         mark_cnt_ff <= mark_cnt_ff + LEN_W'(1);
         if (mark_cnt_ff + LEN_W'(1) == mark_len) begin
            mark_done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROWS; r++) begin
            bm_ff[r] <= '0;
         end
      end else if (cmd.mark_step) begin
         bm_ff[mark_addr[BLK_W-1:COL_W]][mark_addr[COL_W-1:0]] <= cmd.mark_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_ff.status <= cmd.rsp_status;
         if (cmd.rsp_status != ST_OK) begin
            rsp_ff.start_block   <= '0;
            rsp_ff.length_blocks <= '0;
            rsp_ff.keep_blocks   <= '0;
         end else if (cmd.rsp_src == SRC_OLD) begin
            rsp_ff.start_block   <= match_start_ff;
            rsp_ff.length_blocks <= match_len_ff;
            rsp_ff.keep_blocks   <= '0;
         end else begin
            rsp_ff.start_block   <= srch_start_ff;
            rsp_ff.length_blocks <= nblk_ff[LEN_W-1:0];
            rsp_ff.keep_blocks   <= keep_in;
         end
      end
   end

   assign stat.func       = req_ff.func;
   assign stat.size_zero  = req_ff.size_bytes == '0;
   assign stat.hval       = req_ff.handle_valid;
   assign stat.hit_old    = hit_old;
   assign stat.free_found = free_found_ff;
   assign stat.scan_done  = scan_idx_ff == SCAN_W'(TABLE_ENTRIES);
   assign stat.srch_done  = srch_done_ff;
   assign stat.srch_hit   = srch_hit_ff;
   assign stat.mark_done  = mark_done_ff;

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

[hdl/bba_controller.sv]
// Controller of the bitmap block allocator: the state machine that sequences
// table scan, search and marking for each operation.
// Depends on bba_pkg; drives bba_datapath.
module bba_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  bba_pkg::stat_type stat,
   output bba_pkg::cmd_type  cmd,
   output logic              busy
);
   import bba_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      realloc_hit;

   assign realloc_hit = stat.func == FN_REALLOC && stat.hit_old;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd        = '0;
      cmd.rsp_status = ST_OK;
      cmd.rsp_src    = SRC_NEW;
      state_in   = state_ff;
      busy       = state_ff != S_IDLE;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            case (stat.func)
               FN_FREE: begin
                  if (!stat.hval) begin
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = ST_NULL;
                     state_in       = S_IDLE;
                  end else if (!stat.hit_old) begin
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = ST_NOTFOUND;
                     state_in       = S_IDLE;
                  end else begin
                     cmd.mark_init = 1'b1;
                     state_in      = S_CLEAR;
                  end
               end
               default: begin
                  if (realloc_hit) begin
                     cmd.mark_init = 1'b1;
                     state_in      = S_CLEAR;
                  end else if (stat.size_zero) begin
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = ST_ZERO;
                     state_in       = S_IDLE;
                  end else begin
                     cmd.srch_init = 1'b1;
                     state_in      = S_SEARCH;
                  end
               end
            endcase
         end
         S_CLEAR: begin
            cmd.mark_old = 1'b1;
            cmd.mark_val = 1'b0;
            if (!stat.mark_done) begin
               cmd.mark_step = 1'b1;
            end else if (stat.func == FN_FREE) begin
               cmd.invalidate = 1'b1;
               cmd.respond    = 1'b1;
               cmd.rsp_src    = SRC_OLD;
               state_in       = S_IDLE;
            end else if (stat.size_zero) begin
               cmd.invalidate = 1'b1;
               cmd.respond    = 1'b1;
               cmd.rsp_status = ST_ZERO;
               state_in       = S_IDLE;
            end else begin
               cmd.srch_init = 1'b1;
               state_in      = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (!stat.srch_done) begin
               cmd.srch_step = 1'b1;
            end else if (!stat.srch_hit) begin
               if (realloc_hit) begin
                  cmd.mark_init = 1'b1;
                  state_in      = S_RESTORE;
               end else begin
                  cmd.respond    = 1'b1;
                  cmd.rsp_status = ST_NOSPACE;
                  state_in       = S_IDLE;
               end
            end else if (stat.func == FN_PROBE) begin
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end else if (!realloc_hit && !stat.free_found) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = ST_TABLEFULL;
               state_in       = S_IDLE;
            end else begin
               cmd.mark_init = 1'b1;
               state_in      = S_MARK;
            end
         end
         S_RESTORE: begin
            cmd.mark_old = 1'b1;
            cmd.mark_val = 1'b1;
            if (!stat.mark_done) begin
               cmd.mark_step = 1'b1;
            end else begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = ST_NOSPACE;
               state_in       = S_IDLE;
            end
         end
         S_MARK: begin
            cmd.mark_val = 1'b1;
            if (!stat.mark_done) begin
               cmd.mark_step = 1'b1;
            end else begin
               cmd.commit  = 1'b1;
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[hdl/bitmap_block_allocator.sv]
// Top level of the bitmap first-fit block allocator.
// Depends on bba_pkg, bba_controller and bba_datapath.
//
// A request word is taken on req_data at a clock edge where start is high and
// busy is low. busy stays high until the result has been issued; one result
// word per request appears on rsp_data, flagged by rsp_strobe for exactly one
// cycle, and the receiver cannot hold it off.
// Each request first scans the 64-entry allocation table one entry a cycle.
// Allocate, probe and reallocate then walk the occupancy bitmap one block a
// cycle, over up to all 1024 blocks, and marking or clearing a run steps
// through it block by block.
// Synchronous reset marks every block free and every table entry invalid at
// once; the block accepts a request in the cycle after reset is released.
module bitmap_block_allocator (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bba_pkg::req_type req_data,
   output logic             rsp_strobe,
   output bba_pkg::rsp_type rsp_data
);
   import bba_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   bba_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   bba_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after a request word was taken");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result issued while a request is still in progress");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("more than one result word for one request");

   a_error_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status != ST_OK |->
         rsp_data.start_block == '0 && rsp_data.length_blocks == '0 &&
         rsp_data.keep_blocks == '0)
      else $error("error result carries non-zero fields");

endmodule
